@@ rtl/core/csfp_pkg.sv @@
// Shared types, constants and helpers of the circular shell fingerprint core.
// Used by csfp_out_stage and circular_shell_fingerprint_core; no dependencies.
package csfp_pkg;

    // Default sizes of the graph stores
    localparam int DEF_MAX_ATOMS  = 64;
    localparam int DEF_MAX_DEGREE = 8;

    // Results per run before the rest are dropped
    localparam int MAX_OUT = 64;

    // Width used for index and count compares (covers 256 atoms)
    localparam int XW = 9;

    // Per-shell multiplier of the additive mode
    localparam logic [31:0] SHELL_MULT = 32'd7879;

    // Input transaction modes
    localparam logic [1:0] MODE_CLEAR = 2'd0;
    localparam logic [1:0] MODE_LOAD  = 2'd1;
    localparam logic [1:0] MODE_BOND  = 2'd2;
    localparam logic [1:0] MODE_RUN   = 2'd3;

    // Bond kinds
    localparam logic [1:0] BK_SINGLE   = 2'd0;
    localparam logic [1:0] BK_DOUBLE   = 2'd1;
    localparam logic [1:0] BK_TRIPLE   = 2'd2;
    localparam logic [1:0] BK_AROMATIC = 2'd3;

    // Visit status codes
    localparam logic [1:0] ST_NONE  = 2'd0;
    localparam logic [1:0] ST_DONE  = 2'd1;
    localparam logic [1:0] ST_READY = 2'd2;
    localparam logic [1:0] ST_NEXT  = 2'd3;

    // Configuration register indexes
    localparam logic [2:0] CFG_MIN_RADIUS      = 3'd0;
    localparam logic [2:0] CFG_MAX_RADIUS      = 3'd1;
    localparam logic [2:0] CFG_ADDITIVE_MODE   = 3'd2;
    localparam logic [2:0] CFG_UNIFORM_BONDS   = 3'd3;
    localparam logic [2:0] CFG_SHELL_PER_PRINT = 3'd4;
    localparam logic [2:0] CFG_TAIL_RADIUS     = 3'd5;
    localparam logic [2:0] CFG_USE_ISOTOPE     = 3'd6;

    typedef struct packed {
        logic [1:0]  mode;
        logic [5:0]  atom_index;
        logic [31:0] atom_value;
        logic [9:0]  isotope_value;
        logic        include_flag;
        logic [5:0]  neighbour_index;
        logic [1:0]  bond_kind;
        logic [6:0]  atom_count;
    } t_in_item;

    typedef struct packed {
        logic [31:0] bit_value;
        logic [3:0]  print_index;
        logic        has_bit;
        logic        last;
        logic        overflow;
    } t_out_item;

    // Engine to output stage: push one code, or close the run
    typedef struct packed {
        logic        push;
        logic        fin;
        logic        dropped;
        logic [31:0] code;
        logic [3:0]  idx;
    } t_emit_ctl;

    // Bond constant of a bond kind
    function automatic logic [3:0] bond_const(input logic [1:0] kind, input logic uniform);
        logic [3:0] c;
        c = 4'd3;
        if (uniform) begin
            c = 4'd1;
        end else begin
            case (kind)
                BK_AROMATIC: c = 4'd11;
                BK_TRIPLE:   c = 4'd7;
                BK_DOUBLE:   c = 4'd5;
                default:     c = 4'd3;
            endcase
        end
        return c;
    endfunction

endpackage

@@ rtl/core/circular_shell_fingerprint_core.sv @@
// Circular shell fingerprint core: graph stores, shell-growing engine, config registers.
// Depends on csfp_pkg and csfp_out_stage.
//
// Usage: the input channel (i_in_valid / o_in_stall / i_in) carries one transaction
// per graph operation: clear graph, load atom, append bond or run centre. Only the
// run transaction yields results on the output channel (o_out_valid / i_out_stall /
// o_out): between 1 and 64 codes, the final one tagged last, with overflow set if
// codes were dropped. A run with no code gives one transaction with has_bit low.
// The engine handles one transaction at a time; a bond append is a read-modify-write
// of the degree memory. A run seeds the centre's edges, then per shell scans the atoms,
// walks the edges of each ready atom, emits its codes and sweeps the visit states,
// all through the single-port graph memories, each read through an output register.
// A stalled receiver holds the output register and one pending code; the engine
// waits on the next code until the stall clears.
// Reset (synchronous, active low) empties the graph (include flags, degrees), the
// result stage and the engine, and sets the configuration to its defaults.
// Configuration writes (i_cfg_we / i_cfg_index / i_cfg_data) take effect at once.
module circular_shell_fingerprint_core
    import csfp_pkg::*;
#(
    parameter int MAX_ATOMS  = DEF_MAX_ATOMS,
    parameter int MAX_DEGREE = DEF_MAX_DEGREE
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out,
    input  logic      i_cfg_we,
    input  logic [2:0] i_cfg_index,
    input  logic [3:0] i_cfg_data
);

    localparam int AW = $clog2(MAX_ATOMS);
    localparam int JW = $clog2(MAX_DEGREE);
    localparam int DW = $clog2(MAX_DEGREE + 1);
    localparam int SW = $clog2(MAX_ATOMS * MAX_DEGREE);
    localparam int CW = $clog2(MAX_ATOMS + 1);
    localparam int RW = CW + 1;
    localparam int EDGES = MAX_ATOMS * MAX_DEGREE;

    typedef enum logic [17:0] {
        S_IDLE    = 18'h00001,
        S_DISP    = 18'h00002,
        S_BOND    = 18'h00004,
        S_RUN     = 18'h00008,
        S_SHELL   = 18'h00010,
        S_SCAN_RD = 18'h00020,
        S_SCAN_CK = 18'h00040,
        S_E_RD    = 18'h00080,
        S_E_K     = 18'h00100,
        S_E_CHK   = 18'h00200,
        S_E_MIX   = 18'h00400,
        S_EMIT    = 18'h00800,
        S_SHOUT   = 18'h01000,
        S_ISO     = 18'h02000,
        S_LIMIT   = 18'h04000,
        S_SW_RD   = 18'h08000,
        S_SW_CK   = 18'h10000,
        S_FIN     = 18'h20000
    } t_state;

    // Configuration registers
    logic [3:0] r_min_radius, r_max_radius, r_tail_radius;
    logic       r_additive, r_uniform, r_spp, r_use_iso;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_radius  <= 4'd0;
            r_max_radius  <= 4'd0;
            r_additive    <= 1'b1;
            r_uniform     <= 1'b0;
            r_spp         <= 1'b0;
            r_tail_radius <= 4'd0;
            r_use_iso     <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MIN_RADIUS:      r_min_radius  <= i_cfg_data;
                CFG_MAX_RADIUS:      r_max_radius  <= i_cfg_data;
                CFG_ADDITIVE_MODE:   r_additive    <= i_cfg_data[0];
                CFG_UNIFORM_BONDS:   r_uniform     <= i_cfg_data[0];
                CFG_SHELL_PER_PRINT: r_spp         <= i_cfg_data[0];
                CFG_TAIL_RADIUS:     r_tail_radius <= i_cfg_data;
                CFG_USE_ISOTOPE:     r_use_iso     <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Graph and visit memories
    logic [42:0]   m_atom  [MAX_ATOMS];
    logic [DW-1:0] m_deg   [MAX_ATOMS];
    logic [7:0]    m_edge  [EDGES];
    logic [1:0]    m_visit [MAX_ATOMS];

    logic [MAX_ATOMS-1:0] r_aval, r_dval, r_vval, n_aval, n_dval, n_vval;

    logic [42:0]   r_atom_rd;
    logic [DW-1:0] r_deg_rd;
    logic [7:0]    r_edge_rd;
    logic [1:0]    r_visit_rd;
    logic          r_aval_rd, r_dval_rd, r_vval_rd;

    logic [AW-1:0] atom_ra, deg_ra, visit_ra, atom_wa, deg_wa, visit_wa;
    logic [SW-1:0] edge_ra, edge_wa;
    logic          atom_we, deg_we, edge_we, visit_we;
    logic [42:0]   atom_wd;
    logic [DW-1:0] deg_wd;
    logic [7:0]    edge_wd;
    logic [1:0]    visit_wd;

    // Read and write the memories
    always_ff @(posedge i_clk) begin
        if (atom_we) begin
            m_atom[atom_wa] <= atom_wd;
        end
        if (deg_we) begin
            m_deg[deg_wa] <= deg_wd;
        end
        if (edge_we) begin
            m_edge[edge_wa] <= edge_wd;
        end
        if (visit_we) begin
            m_visit[visit_wa] <= visit_wd;
        end
        r_atom_rd  <= m_atom[atom_ra];
        r_deg_rd   <= m_deg[deg_ra];
        r_edge_rd  <= m_edge[edge_ra];
        r_visit_rd <= m_visit[visit_ra];
        r_aval_rd  <= r_aval[atom_ra];
        r_dval_rd  <= r_dval[deg_ra];
        r_vval_rd  <= r_vval[visit_ra];
    end

    // Decoded read data
    logic          rd_incl;
    logic [9:0]    rd_iso;
    logic [31:0]   rd_const;
    logic [DW-1:0] rd_deg;
    logic [1:0]    rd_vis;
    logic [5:0]    rd_k;
    logic [1:0]    rd_kind;

    assign rd_incl  = r_aval_rd & r_atom_rd[42];
    assign rd_iso   = r_atom_rd[41:32];
    assign rd_const = r_atom_rd[31:0];
    assign rd_deg   = r_dval_rd ? r_deg_rd : '0;
    assign rd_vis   = r_vval_rd ? r_visit_rd : ST_NONE;
    assign rd_k     = r_edge_rd[7:2];
    assign rd_kind  = r_edge_rd[1:0];

    // Engine registers
    t_state        r_state, n_state, r_ret, n_ret;
    t_in_item      r_item, n_item;
    logic [CW-1:0] r_count, n_count, r_i, n_i;
    logic [AW-1:0] r_centre, n_centre;
    logic [31:0]   r_code, n_code, r_term, n_term, r_cconst, n_cconst, r_ecode, n_ecode;
    logic [9:0]    r_iso, n_iso;
    logic [RW-1:0] r_radius, n_radius;
    logic [DW-1:0] r_j, n_j, r_cdeg, n_cdeg;
    logic [5:0]    r_k, n_k;
    logic [1:0]    r_kind, n_kind;
    logic          r_seed, n_seed, r_more, n_more, r_dropped, n_dropped;
    logic [6:0]    r_emitted, n_emitted;
    logic [3:0]    r_eidx, n_eidx;

    t_emit_ctl     ctl;
    logic          gnt;

    // Helper values
    logic [XW-1:0] a_ext, cnt_ext, lim_ext, cnt_sat;
    logic          a_ok;
    logic [AW-1:0] a_addr;
    logic [SW-1:0] slot_run, slot_bond;
    logic [CW-1:0] i_inc;
    logic [DW-1:0] j_inc;
    logic          tails;
    logic [3:0]    idx_now;
    logic [31:0]   mix_code;

    assign a_ext     = XW'(r_item.atom_index);
    assign lim_ext   = XW'(MAX_ATOMS);
    assign cnt_ext   = XW'(r_item.atom_count);
    assign cnt_sat   = (cnt_ext > lim_ext) ? lim_ext : cnt_ext;
    assign a_ok      = a_ext < lim_ext;
    assign a_addr    = AW'(r_item.atom_index);
    assign slot_run  = SW'(AW'(r_i)) * SW'(MAX_DEGREE) + SW'(JW'(r_j));
    assign slot_bond = SW'(a_addr) * SW'(MAX_DEGREE) + SW'(JW'(rd_deg));
    assign i_inc     = CW'(r_i + CW'(1));
    assign j_inc     = DW'(r_j + DW'(1));
    assign tails     = (r_tail_radius != 4'd0) && (r_radius <= RW'(r_tail_radius));
    assign idx_now   = !r_spp ? 4'd0 :
                       (r_radius > RW'(15)) ? 4'd15 : 4'(r_radius);
    assign mix_code  = r_additive ? (r_code + r_term) : 32'(r_code * r_term);

    assign o_in_stall = (r_state != S_IDLE);

    // Engine next state
    always_comb begin
        n_state   = r_state;
        n_ret     = r_ret;
        n_item    = r_item;
        n_count   = r_count;
        n_i       = r_i;
        n_centre  = r_centre;
        n_code    = r_code;
        n_term    = r_term;
        n_cconst  = r_cconst;
        n_ecode   = r_ecode;
        n_eidx    = r_eidx;
        n_iso     = r_iso;
        n_radius  = r_radius;
        n_j       = r_j;
        n_cdeg    = r_cdeg;
        n_k       = r_k;
        n_kind    = r_kind;
        n_seed    = r_seed;
        n_more    = r_more;
        n_dropped = r_dropped;
        n_emitted = r_emitted;
        n_aval    = r_aval;
        n_dval    = r_dval;
        n_vval    = r_vval;
        atom_ra   = '0;
        deg_ra    = '0;
        visit_ra  = '0;
        edge_ra   = '0;
        atom_we   = 1'b0;
        atom_wa   = a_addr;
        atom_wd   = {r_item.include_flag, r_item.isotope_value, r_item.atom_value};
        deg_we    = 1'b0;
        deg_wa    = a_addr;
        deg_wd    = DW'(rd_deg + DW'(1));
        edge_we   = 1'b0;
        edge_wa   = slot_bond;
        edge_wd   = {r_item.neighbour_index, r_item.bond_kind};
        visit_we  = 1'b0;
        visit_wa  = AW'(r_k);
        visit_wd  = ST_NONE;
        ctl       = '0;

        case (r_state)
            // Take one transaction
            S_IDLE: begin
                if (i_in_valid) begin
                    n_item  = i_in;
                    n_state = S_DISP;
                end
            end

            S_DISP: begin
                n_state = S_IDLE;
                case (r_item.mode)
                    MODE_CLEAR: begin
                        n_aval = '0;
                        n_dval = '0;
                    end
                    MODE_LOAD: begin
                        if (a_ok) begin
                            atom_we        = 1'b1;
                            n_aval[a_addr] = 1'b1;
                        end
                    end
                    MODE_BOND: begin
                        deg_ra = a_addr;
                        if (a_ok) begin
                            n_state = S_BOND;
                        end
                    end
                    default: begin
                        // Run: fetch the centre, reset run state
                        atom_ra   = a_addr;
                        deg_ra    = a_addr;
                        n_count   = CW'(cnt_sat);
                        n_centre  = a_addr;
                        n_vval    = '0;
                        n_emitted = '0;
                        n_dropped = 1'b0;
                        n_radius  = '0;
                        n_state   = (a_ok && (a_ext < cnt_sat)) ? S_RUN : S_FIN;
                    end
                endcase
            end

            // Append the bond if the list has room
            S_BOND: begin
                n_state = S_IDLE;
                if (rd_deg < DW'(MAX_DEGREE)) begin
                    edge_we        = 1'b1;
                    deg_we         = 1'b1;
                    n_dval[a_addr] = 1'b1;
                end
            end

            // Start at the centre, then seed its neighbours
            S_RUN: begin
                if (!rd_incl) begin
                    n_state = S_FIN;
                end else begin
                    n_code             = rd_const;
                    n_iso              = r_use_iso ? rd_iso : 10'd0;
                    visit_we           = 1'b1;
                    visit_wa           = r_centre;
                    visit_wd           = ST_DONE;
                    n_vval[r_centre]   = 1'b1;
                    n_cdeg             = rd_deg;
                    n_i                = CW'(r_centre);
                    n_j                = '0;
                    n_seed             = 1'b1;
                    if (r_min_radius == 4'd0) begin
                        n_ecode = rd_const;
                        n_eidx  = 4'd0;
                        n_ret   = S_E_RD;
                        n_state = S_EMIT;
                    end else begin
                        n_state = S_E_RD;
                    end
                end
            end

            // Open a shell
            S_SHELL: begin
                n_radius = RW'(r_radius + RW'(1));
                if (r_additive) begin
                    n_code = 32'(r_code * SHELL_MULT);
                end
                n_i     = '0;
                n_state = S_SCAN_RD;
            end

            S_SCAN_RD: begin
                atom_ra  = AW'(r_i);
                deg_ra   = AW'(r_i);
                visit_ra = AW'(r_i);
                n_state  = S_SCAN_CK;
            end

            S_SCAN_CK: begin
                if (rd_vis == ST_READY) begin
                    n_cconst = rd_const;
                    n_cdeg   = rd_deg;
                    n_j      = '0;
                    n_state  = S_E_RD;
                end else begin
                    n_i     = i_inc;
                    n_state = (i_inc >= r_count) ? S_SHOUT : S_SCAN_RD;
                end
            end

            // Walk the edges of the current atom
            S_E_RD: begin
                if (r_j >= r_cdeg) begin
                    if (r_seed) begin
                        n_seed  = 1'b0;
                        n_state = S_SHELL;
                    end else begin
                        n_i     = i_inc;
                        n_state = (i_inc >= r_count) ? S_SHOUT : S_SCAN_RD;
                    end
                end else begin
                    edge_ra = slot_run;
                    n_state = S_E_K;
                end
            end

            S_E_K: begin
                if (XW'(rd_k) >= XW'(r_count)) begin
                    n_j     = j_inc;
                    n_state = S_E_RD;
                end else begin
                    atom_ra  = AW'(rd_k);
                    visit_ra = AW'(rd_k);
                    n_k      = rd_k;
                    n_kind   = rd_kind;
                    n_state  = S_E_CHK;
                end
            end

            S_E_CHK: begin
                n_j     = j_inc;
                n_state = S_E_RD;
                if (rd_incl) begin
                    if (r_seed) begin
                        visit_we         = 1'b1;
                        visit_wd         = ST_READY;
                        n_vval[AW'(r_k)] = 1'b1;
                    end else if (rd_vis == ST_DONE) begin
                        n_term  = 32'(32'(bond_const(r_kind, r_uniform)) * r_cconst);
                        n_j     = r_j;
                        n_state = S_E_MIX;
                    end else if (rd_vis != ST_READY) begin
                        visit_we         = 1'b1;
                        visit_wd         = ST_NEXT;
                        n_vval[AW'(r_k)] = 1'b1;
                    end
                end
            end

            // Mix the term in, optionally emit a tail code
            S_E_MIX: begin
                n_code = mix_code;
                n_j    = j_inc;
                if (tails) begin
                    n_ecode = mix_code;
                    n_eidx  = idx_now;
                    n_ret   = S_E_RD;
                    n_state = S_EMIT;
                end else begin
                    n_state = S_E_RD;
                end
            end

            // Hand one code to the output stage, or drop it past the cap
            S_EMIT: begin
                if (r_emitted >= 7'(MAX_OUT)) begin
                    n_dropped = 1'b1;
                    n_state   = r_ret;
                end else begin
                    ctl.push = 1'b1;
                    ctl.code = r_ecode;
                    ctl.idx  = r_eidx;
                    if (gnt) begin
                        n_emitted = 7'(r_emitted + 7'd1);
                        n_state   = r_ret;
                    end
                end
            end

            // Shell code
            S_SHOUT: begin
                if (r_radius >= RW'(r_min_radius)) begin
                    n_ecode = r_code;
                    n_eidx  = idx_now;
                    n_ret   = S_ISO;
                    n_state = S_EMIT;
                end else begin
                    n_state = S_LIMIT;
                end
            end

            // Isotope-offset code
            S_ISO: begin
                if (r_iso != 10'd0) begin
                    n_ecode = r_code + 32'(r_iso);
                    n_eidx  = idx_now;
                    n_ret   = S_LIMIT;
                    n_state = S_EMIT;
                end else begin
                    n_state = S_LIMIT;
                end
            end

            S_LIMIT: begin
                if ((r_max_radius != 4'd0) && (r_radius >= RW'(r_max_radius))) begin
                    n_state = S_FIN;
                end else begin
                    n_i     = '0;
                    n_more  = 1'b0;
                    n_state = S_SW_RD;
                end
            end

            // Advance ready to done and next to ready
            S_SW_RD: begin
                visit_ra = AW'(r_i);
                n_state  = S_SW_CK;
            end

            S_SW_CK: begin
                visit_wa = AW'(r_i);
                if (rd_vis == ST_READY) begin
                    visit_we = 1'b1;
                    visit_wd = ST_DONE;
                end else if (rd_vis == ST_NEXT) begin
                    visit_we = 1'b1;
                    visit_wd = ST_READY;
                    n_more   = 1'b1;
                end
                n_i = i_inc;
                if (i_inc >= r_count) begin
                    n_state = (r_more || (rd_vis == ST_NEXT)) ? S_SHELL : S_FIN;
                end else begin
                    n_state = S_SW_RD;
                end
            end

            // Close the run
            S_FIN: begin
                ctl.fin     = 1'b1;
                ctl.dropped = r_dropped;
                if (gnt) begin
                    n_state = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_aval  <= '0;
            r_dval  <= '0;
            r_vval  <= '0;
        end else begin
            r_state <= n_state;
            r_aval  <= n_aval;
            r_dval  <= n_dval;
            r_vval  <= n_vval;
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        r_ret     <= n_ret;
        r_item    <= n_item;
        r_count   <= n_count;
        r_i       <= n_i;
        r_centre  <= n_centre;
        r_code    <= n_code;
        r_term    <= n_term;
        r_cconst  <= n_cconst;
        r_ecode   <= n_ecode;
        r_eidx    <= n_eidx;
        r_iso     <= n_iso;
        r_radius  <= n_radius;
        r_j       <= n_j;
        r_cdeg    <= n_cdeg;
        r_k       <= n_k;
        r_kind    <= n_kind;
        r_seed    <= n_seed;
        r_more    <= n_more;
        r_dropped <= n_dropped;
        r_emitted <= n_emitted;
    end

    csfp_out_stage u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl),
        .o_gnt       (gnt),
        .o_out_valid (o_out_valid),
        .o_out       (o_out),
        .i_out_stall (i_out_stall)
    );

endmodule

@@ rtl/core/csfp_out_stage.sv @@
// Result staging of the fingerprint core: one pending code plus the output register.
// Holds the newest code back so the last one of a run can be tagged. Uses csfp_pkg.
module csfp_out_stage
    import csfp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_emit_ctl i_ctl,
    output logic      o_gnt,
    output logic      o_out_valid,
    output t_out_item o_out,
    input  logic      i_out_stall
);

    logic      r_pend_v;
    logic      r_out_v;
    t_out_item r_pend;
    t_out_item r_out;
    logic      out_free;
    logic      push_gnt;
    logic      fin_gnt;

    // Output register can take a new transaction this cycle
    assign out_free = !r_out_v || !i_out_stall;
    assign push_gnt = i_ctl.push && (!r_pend_v || out_free);
    assign fin_gnt  = i_ctl.fin && out_free;
    assign o_gnt    = push_gnt || fin_gnt;

    // Valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            if (r_out_v && !i_out_stall) begin
                r_out_v <= 1'b0;
            end
            if (push_gnt) begin
                r_pend_v <= 1'b1;
                if (r_pend_v) begin
                    r_out_v <= 1'b1;
                end
            end
            if (fin_gnt) begin
                r_pend_v <= 1'b0;
                r_out_v  <= 1'b1;
            end
        end
    end

    // Payload: shift pending into output, tag the final one
    always_ff @(posedge i_clk) begin
        if (push_gnt) begin
            if (r_pend_v) begin
                r_out <= r_pend;
            end
            r_pend.bit_value   <= i_ctl.code;
            r_pend.print_index <= i_ctl.idx;
            r_pend.has_bit     <= 1'b1;
            r_pend.last        <= 1'b0;
            r_pend.overflow    <= 1'b0;
        end
        if (fin_gnt) begin
            if (r_pend_v) begin
                r_out.bit_value   <= r_pend.bit_value;
                r_out.print_index <= r_pend.print_index;
                r_out.has_bit     <= 1'b1;
                r_out.overflow    <= i_ctl.dropped;
            end else begin
                r_out.bit_value   <= 32'd0;
                r_out.print_index <= 4'd0;
                r_out.has_bit     <= 1'b0;
                r_out.overflow    <= 1'b0;
            end
            r_out.last <= 1'b1;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out       = r_out;

`ifndef SYNTHESIS
    a_one_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_ctl.push && i_ctl.fin))
        else $error("push and finish requested together");

    a_fin_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fin_gnt |=> (!r_pend_v && r_out_v && r_out.last))
        else $error("finish did not close the run");

    a_push_shifts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push_gnt && r_pend_v) |=> (r_out_v && !r_out.last && r_pend_v))
        else $error("pending code not moved to output");
`endif

endmodule
